// ===== rtl/core/sdp_pkg.sv =====
// shared types, constants and functions of the sha-256 pair scan unit
// no dependencies
package sdp_pkg;

  localparam int DefaultRounds = 57;
  localparam int WordW = 32;
  localparam int DistW = 9;
  localparam int PopW = 6;

  localparam logic [WordW-1:0] FillReset = 32'hffff_ffff;
  localparam logic [4:0] KernelReset = 5'd31;

  typedef enum logic [0:0] {
    CFG_FILL_WORD  = 1'b0,
    CFG_KERNEL_POS = 1'b1
  } cfg_reg_t;

  localparam logic [WordW-1:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0][WordW-1:0] InitH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // one pipeline slot: both schedule windows, both working states, the candidate
  typedef struct packed {
    logic [15:0][WordW-1:0] w1;
    logic [15:0][WordW-1:0] w2;
    logic [7:0][WordW-1:0]  v1;
    logic [7:0][WordW-1:0]  v2;
    logic [WordW-1:0]       cand;
  } lane_t;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] big_sig0(input logic [WordW-1:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WordW-1:0] big_sig1(input logic [WordW-1:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [WordW-1:0] small_sig0(input logic [WordW-1:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] small_sig1(input logic [WordW-1:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [PopW-1:0] popcount32(input logic [WordW-1:0] x);
    logic [PopW-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < WordW; i++) begin
      cnt = cnt + PopW'(x[i]);
    end
    return cnt;
  endfunction

endpackage

// ===== rtl/core/sdp_cand_if.sv =====
// candidate word channel of the sha-256 pair scan unit
// no dependencies
interface sdp_cand_if;
  logic        valid;
  logic        ready;
  logic [31:0] candidate_word;

  modport source (output valid, output candidate_word, input ready);
  modport sink (input valid, input candidate_word, output ready);
endinterface

// ===== rtl/core/sdp_res_if.sv =====
// result word channel of the sha-256 pair scan unit
// no dependencies
interface sdp_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] candidate_echo;
  logic        a_match;
  logic [8:0]  state_distance;

  modport source (output valid, output candidate_echo, output a_match,
                  output state_distance, input ready);
  modport sink (input valid, input candidate_echo, input a_match,
                input state_distance, output ready);
endinterface

// ===== rtl/core/sha256_differential_pair_scan_unit.sv =====
// Differential pair scan over SHA-256: each candidate word builds two messages (fill word
// everywhere, candidate in word 0, the second message flipped at the kernel bit position in
// words 0 and 9), runs ROUNDS compression rounds on both and reports a-match and the state
// Hamming distance. One candidate word is taken every cycle while the result side keeps up;
// a result word waiting at the output stalls the whole chain and with it the input once the
// popcount stage also holds a word. Between acceptance and the result lie one round cell per
// round, then a popcount stage and the output register. Configuration writes are meant to be
// made with no candidate in flight.
// depends on sdp_pkg, sdp_cand_if, sdp_res_if, sdp_round_cell, sdp_dist_cell
module sha256_differential_pair_scan_unit #(
  parameter int ROUNDS = sdp_pkg::DefaultRounds
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  sdp_pkg::cfg_reg_t       cfg_index,
  input  logic [31:0]             cfg_data,
  sdp_cand_if.sink                cand,
  sdp_res_if.source               res
);
  import sdp_pkg::*;

  logic [WordW-1:0] fill_word;
  logic [4:0]       kernel_pos;
  logic [WordW-1:0] mask;
  logic             advance;
  logic [ROUNDS:0]  stage_valid;
  lane_t            lane [ROUNDS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_word  <= FillReset;
      kernel_pos <= KernelReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILL_WORD:  fill_word  <= cfg_data;
        CFG_KERNEL_POS: kernel_pos <= cfg_data[4:0];
        default:        fill_word  <= fill_word;
      endcase
    end
  end

  assign mask = WordW'(1) << kernel_pos;
  assign cand.ready = advance;
  assign stage_valid[0] = cand.valid;

  always_comb begin
    lane[0].cand = cand.candidate_word;
    lane[0].v1   = InitH;
    lane[0].v2   = InitH;
    for (int j = 0; j < 16; j++) begin
      lane[0].w1[j] = fill_word;
      lane[0].w2[j] = fill_word;
    end
    lane[0].w1[0] = cand.candidate_word;
    lane[0].w2[0] = cand.candidate_word ^ mask;
    lane[0].w2[9] = fill_word ^ mask;
  end

  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    sdp_round_cell #(
      .Idx (i)
    ) u_round (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .valid_in  (stage_valid[i]),
      .lane_in   (lane[i]),
      .valid_out (stage_valid[i+1]),
      .lane_out  (lane[i+1])
    );
  end

  sdp_dist_cell u_dist (
    .clk      (clk),
    .rst      (rst),
    .valid_in (stage_valid[ROUNDS]),
    .lane_in  (lane[ROUNDS]),
    .advance  (advance),
    .res      (res)
  );

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(stage_valid[ROUNDS:1]))
    else $error("round chain moved while stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    cand.valid && cand.ready |=> stage_valid[1])
    else $error("accepted word missing from first round");

  a_free_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res.valid |-> cand.ready)
    else $error("input blocked with empty output");
`endif

endmodule

// ===== rtl/core/sdp_round_cell.sv =====
// one sha-256 round for both messages plus one schedule step, registered
// depends on sdp_pkg
module sdp_round_cell #(
  parameter int Idx = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic          valid_in,
  input  sdp_pkg::lane_t lane_in,
  output logic          valid_out,
  output sdp_pkg::lane_t lane_out
);
  import sdp_pkg::*;

  localparam logic [WordW-1:0] KConst = RoundK[Idx % 64];

  lane_t lane_next;

  function automatic logic [7:0][WordW-1:0] do_round(input logic [7:0][WordW-1:0] v,
                                                     input logic [WordW-1:0] wi);
    logic [WordW-1:0] t1;
    logic [WordW-1:0] t2;
    logic [7:0][WordW-1:0] r;
    t1 = v[7] + big_sig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KConst + wi;
    t2 = big_sig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    r[7] = v[6];
    r[6] = v[5];
    r[5] = v[4];
    r[4] = v[3] + t1;
    r[3] = v[2];
    r[2] = v[1];
    r[1] = v[0];
    r[0] = t1 + t2;
    return r;
  endfunction

  // window slides by one word; the new top word is w[i+16]
  function automatic logic [15:0][WordW-1:0] slide(input logic [15:0][WordW-1:0] w);
    logic [15:0][WordW-1:0] r;
    for (int j = 0; j < 15; j++) begin
      r[j] = w[j+1];
    end
    r[15] = small_sig1(w[14]) + w[9] + small_sig0(w[1]) + w[0];
    return r;
  endfunction

  always_comb begin
    lane_next.cand = lane_in.cand;
    lane_next.v1   = do_round(lane_in.v1, lane_in.w1[0]);
    lane_next.v2   = do_round(lane_in.v2, lane_in.w2[0]);
    lane_next.w1   = slide(lane_in.w1);
    lane_next.w2   = slide(lane_in.w2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (advance) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lane_out <= lane_next;
    end
  end

endmodule

// ===== rtl/core/sdp_dist_cell.sv =====
// compare stage: per-word popcount of the state difference, then sum into the output register
// depends on sdp_pkg and sdp_res_if
module sdp_dist_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           valid_in,
  input  sdp_pkg::lane_t lane_in,
  output logic           advance,
  sdp_res_if.source      res
);
  import sdp_pkg::*;

  logic                   pc_valid;
  logic [7:0][PopW-1:0]   pc_count;
  logic                   pc_match;
  logic [WordW-1:0]       pc_cand;
  logic [DistW-1:0]       dist_sum;
  logic                   out_free;

  assign out_free = !res.valid || res.ready;
  assign advance  = !pc_valid || out_free;

  always_comb begin
    dist_sum = '0;
    for (int i = 0; i < 8; i++) begin
      dist_sum = dist_sum + DistW'(pc_count[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc_valid  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (advance) begin
        pc_valid <= valid_in;
      end
      if (out_free) begin
        res.valid <= pc_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 8; i++) begin
        pc_count[i] <= popcount32(lane_in.v1[i] ^ lane_in.v2[i]);
      end
      pc_match <= (lane_in.v1[0] == lane_in.v2[0]);
      pc_cand  <= lane_in.cand;
    end
    if (out_free) begin
      res.candidate_echo <= pc_cand;
      res.a_match        <= pc_match;
      res.state_distance <= dist_sum;
    end
  end

`ifndef SYNTHESIS
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.state_distance <= 9'd256)
    else $error("distance above 256");

  a_zero_dist_match: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.state_distance == '0 |-> res.a_match)
    else $error("zero distance without a match");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.state_distance))
    else $error("stalled result changed");
`endif

endmodule

// ===== tb/sha256_differential_pair_scan_unit_tb.sv =====
`timescale 1ns / 100ps
// testbench for the sha-256 differential pair scan unit: directed table, then random phases
// checked against a local model of the 57-round pair; depends on sdp_pkg, sdp_cand_if,
// sdp_res_if and sha256_differential_pair_scan_unit
module sha256_differential_pair_scan_unit_tb;
  import sdp_pkg::*;

  localparam int ScanRounds = 57;
  localparam int PipeDepth = ScanRounds + 2;
  localparam int CycleLimit = 500000;
  localparam int NumPhases = 8;
  localparam int WordsPerPhase = 128;
  localparam int LongHold = 400;
  localparam int PressurePhase = 2;

  typedef struct packed {
    logic [31:0] echo;
    logic        a_match;
    logic [8:0]  distance;
  } scan_result_t;

  typedef enum logic {
    ROW_CONFIG,
    ROW_WORD
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_reg_t    sel;
    logic [31:0] data;
  } scan_row_t;

  localparam int NumRows = 22;
  localparam scan_row_t DirRows [NumRows] = '{
    '{ROW_WORD,   CFG_FILL_WORD,  32'h0000_0000},
    '{ROW_WORD,   CFG_FILL_WORD,  32'hffff_ffff},
    '{ROW_WORD,   CFG_FILL_WORD,  32'h8000_0000},
    '{ROW_WORD,   CFG_FILL_WORD,  32'h7fff_ffff},
    '{ROW_CONFIG, CFG_FILL_WORD,  32'h0000_0000},
    '{ROW_WORD,   CFG_FILL_WORD,  32'h0000_0000},
    '{ROW_WORD,   CFG_FILL_WORD,  32'hffff_ffff},
    '{ROW_CONFIG, CFG_KERNEL_POS, 32'h0000_0000},
    '{ROW_WORD,   CFG_FILL_WORD,  32'h0000_0000},
    '{ROW_WORD,   CFG_FILL_WORD,  32'h0000_0001},
    // only the low five bits of a kernel write are kept
    '{ROW_CONFIG, CFG_KERNEL_POS, 32'hdead_bee3},
    '{ROW_WORD,   CFG_FILL_WORD,  32'h0000_0008},
    '{ROW_CONFIG, CFG_FILL_WORD,  32'hffff_ffff},
    '{ROW_CONFIG, CFG_KERNEL_POS, 32'hffff_ffff},
    '{ROW_WORD,   CFG_FILL_WORD,  32'ha5a5_a5a5},
    '{ROW_WORD,   CFG_FILL_WORD,  32'h5a5a_5a5a},
    '{ROW_CONFIG, CFG_KERNEL_POS, 32'hbeef_0010},
    '{ROW_CONFIG, CFG_FILL_WORD,  32'h1234_5678},
    '{ROW_WORD,   CFG_FILL_WORD,  32'h0000_0000},
    '{ROW_WORD,   CFG_FILL_WORD,  32'h1234_5678},
    '{ROW_WORD,   CFG_FILL_WORD,  32'hffff_ffff},
    '{ROW_WORD,   CFG_FILL_WORD,  32'h1235_5678}
  };

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] StartState [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic        clk;
  logic        rst;
  logic        cfg_we;
  cfg_reg_t    cfg_index;
  logic [31:0] cfg_data;

  sdp_cand_if cand_ch ();
  sdp_res_if  res_ch ();

  sha256_differential_pair_scan_unit #(
    .ROUNDS(ScanRounds)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cand(cand_ch.sink),
    .res(res_ch.source)
  );

  logic [31:0]  fill_copy;
  logic [4:0]   kernel_copy;
  scan_result_t pending_q [$];
  int           errors = 0;
  int           words_sent = 0;
  int           results_seen = 0;
  int           settings_used = 0;
  int           cycle_count = 0;
  bit           hold_req = 1'b0;
  bit           streaming = 1'b0;
  bit           tx_back_to_back = 1'b0;
  bit           rx_back_to_back = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    logic [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  function automatic logic [7:0][31:0] run_rounds(input logic [15:0][31:0] msg);
    logic [15:0][31:0] sched;
    logic [7:0][31:0]  v;
    logic [31:0]       wi, t1, t2, x15, x2, e, a;
    sched = msg;
    for (int j = 0; j < 8; j++) v[j] = StartState[j];
    for (int r = 0; r < ScanRounds; r++) begin
      if (r < 16) begin
        wi = sched[r];
      end else begin
        x15 = sched[(r - 15) & 15];
        x2 = sched[(r - 2) & 15];
        wi = (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10)) + sched[(r - 7) & 15]
           + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3)) + sched[r & 15];
        sched[r & 15] = wi;
      end
      e = v[4];
      a = v[0];
      t1 = v[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
         + ((e & v[5]) ^ (~e & v[6])) + RoundConst[r & 63] + wi;
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
         + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    return v;
  endfunction

  function automatic scan_result_t predict_pair(input logic [31:0] cand);
    logic [31:0]       mask;
    logic [15:0][31:0] m1, m2;
    logic [7:0][31:0]  s1, s2;
    int                popsum;
    scan_result_t      r;
    mask = 32'h1 << kernel_copy;
    m1 = {16{fill_copy}};
    m2 = m1;
    m1[0] = cand;
    m2[0] = cand ^ mask;
    m2[9] = fill_copy ^ mask;
    s1 = run_rounds(m1);
    s2 = run_rounds(m2);
    popsum = 0;
    for (int j = 0; j < 8; j++) popsum += $countones(s1[j] ^ s2[j]);
    r.echo = cand;
    r.a_match = (s1[0] == s2[0]);
    r.distance = popsum[8:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_candidate();
    logic [31:0] mask;
    mask = 32'h1 << kernel_copy;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hffff_ffff;
      1: return $urandom_range(0, 1) ? fill_copy : fill_copy ^ mask;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input cfg_reg_t sel, input logic [31:0] value);
    while (pending_q.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_FILL_WORD) fill_copy = value;
    else kernel_copy = value[4:0];
    settings_used++;
  endtask

  // valid stays high into the next word when no gap follows
  task automatic send_word(input logic [31:0] word, input bit more);
    int gap;
    cand_ch.valid <= 1'b1;
    cand_ch.candidate_word <= word;
    @(posedge clk);
    while (!cand_ch.ready) @(posedge clk);
    pending_q.push_back(predict_pair(word));
    words_sent++;
    if (words_sent % 32 == 0) tx_back_to_back = ($urandom_range(0, 3) == 0);
    if (!more) gap = 1;
    else if (streaming || tx_back_to_back) gap = 0;
    else gap = $urandom_range(0, 15);
    if (gap > 0) begin
      cand_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : result_sink
    int           stall;
    scan_result_t want;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        for (int c = 0; c < LongHold; c++) @(posedge clk);
        hold_req = 1'b0;
      end
      if (results_seen % 40 == 0) rx_back_to_back = ($urandom_range(0, 3) == 0);
      stall = rx_back_to_back ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected result word, candidate_echo %h", res_ch.candidate_echo);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (res_ch.candidate_echo !== want.echo) begin
          $error("candidate_echo: expected %h, got %h", want.echo, res_ch.candidate_echo);
          errors++;
        end
        if (res_ch.a_match !== want.a_match) begin
          $error("a_match: expected %0d, got %0d", want.a_match, res_ch.a_match);
          errors++;
        end
        if (res_ch.state_distance !== want.distance) begin
          $error("state_distance: expected %0d, got %0d", want.distance,
                 res_ch.state_distance);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] fill_v;
    logic [31:0] kern_v;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_FILL_WORD;
    cfg_data <= '0;
    cand_ch.valid <= 1'b0;
    cand_ch.candidate_word <= '0;
    fill_copy = 32'hffff_ffff;
    kernel_copy = 5'd31;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NumRows; i++) begin
      if (DirRows[i].kind == ROW_CONFIG) write_reg(DirRows[i].sel, DirRows[i].data);
      else send_word(DirRows[i].data, (i + 1 < NumRows) && (DirRows[i+1].kind == ROW_WORD));
    end

    for (int p = 0; p < NumPhases; p++) begin
      kern_v = $urandom;
      case (p)
        0: begin
          fill_v = 32'h0000_0000;
          kern_v[4:0] = 5'd0;
        end
        1: begin
          fill_v = 32'hffff_ffff;
          kern_v[4:0] = 5'd31;
        end
        default: fill_v = $urandom;
      endcase
      write_reg(CFG_FILL_WORD, fill_v);
      write_reg(CFG_KERNEL_POS, kern_v);
      // back up the pipeline: output held off while words stream in
      if (p == PressurePhase) begin
        hold_req = 1'b1;
        streaming = 1'b1;
      end
      for (int n = 0; n < WordsPerPhase; n++) send_word(pick_candidate(), n + 1 < WordsPerPhase);
      streaming = 1'b0;
    end

    while (pending_q.size() != 0) @(posedge clk);
    repeat (PipeDepth + 8) @(posedge clk);
    $display("scanned %0d candidate words under %0d register writes, %0d results compared",
             words_sent, settings_used, results_seen);
    $display("output held off once for %0d cycles to stall the input side", LongHold);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
